// File: rtl/fsnr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnr_pkg - shared types and constants of the first-seen node relabeler
// Widths, error codes, register map and the controller/datapath interface.
// ----------------------------------------------------------------------------
package fsnr_pkg;

    localparam int NODE_ID_SPACE   = 65536;
    localparam int MAX_BATCH_NODES = 2048;

    localparam int ID_W    = $clog2(NODE_ID_SPACE);       // node id / map address
    localparam int LABEL_W = $clog2(MAX_BATCH_NODES);     // dense label / list address
    localparam int COUNT_W = LABEL_W + 1;                 // 0 .. MAX_BATCH_NODES
    localparam int MAP_W   = LABEL_W + 1;                 // valid flag + label
    localparam int CLR_W   = ID_W + 1;                    // sweep counter incl. done
    localparam int LIMIT_W = 17;
    localparam int ERR_W   = 2;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_NODE_COUNT_LIMIT = 1'b0;         // word index, paddr[2]
    localparam logic [LIMIT_W-1:0] NODE_LIMIT_RESET = LIMIT_W'(65536);

    // result error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CAPACITY = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CLEAR,     // reset sweep of the label map
        CMD_ACCEPT,    // latch beat, read map at source
        CMD_LOOK_DST,  // hold source entry, read map at destination
        CMD_DECIDE,    // labels, errors, first write
        CMD_WR_DST,    // second write when both nodes are new
        CMD_FLUSH,     // walk the node list, invalidate map entries
        CMD_LOAD       // move result into the output register
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic both_new;
        logic end_flag;
        logic flush_done;
    } status_t;

endpackage

// File: rtl/fsnr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnr_ram - generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module fsnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/fsnr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnr_datapath - label map, node list, counters and result register
// Executes one controller command per cycle.
// ----------------------------------------------------------------------------
module fsnr_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fsnr_pkg::cmd_t               cmd,
    output fsnr_pkg::status_t            status,
    input  logic [fsnr_pkg::LIMIT_W-1:0] node_count_limit,
    input  logic [fsnr_pkg::ID_W-1:0]    s_source_node,
    input  logic [fsnr_pkg::ID_W-1:0]    s_target_node,
    input  logic                         s_batch_end,
    output logic [fsnr_pkg::LABEL_W-1:0] m_source_label,
    output logic [fsnr_pkg::LABEL_W-1:0] m_target_label,
    output logic                         m_source_first_seen,
    output logic                         m_target_first_seen,
    output logic [fsnr_pkg::ERR_W-1:0]   m_error_code,
    output logic [fsnr_pkg::COUNT_W-1:0] m_batch_node_total,
    output logic                         m_batch_done
);
    import fsnr_pkg::*;

    localparam logic [COUNT_W:0] CAPACITY = (COUNT_W+1)'(MAX_BATCH_NODES);

    // beat and lookup
    logic [ID_W-1:0]    src_reg, dst_reg;
    logic               end_reg, range_err_reg;
    logic [MAP_W-1:0]   src_ent_reg;
    logic [LABEL_W-1:0] src_lab_reg, dst_lab_reg;
    logic               src_new_reg, dst_new_reg;
    logic [ERR_W-1:0]   err_reg;
    // counters
    logic [COUNT_W-1:0] nfl_reg, fcnt_reg, total_reg;
    logic               fpend_reg;
    logic [CLR_W-1:0]   clr_cnt_reg;
    // output register
    logic [LABEL_W-1:0] out_src_lab_reg, out_dst_lab_reg;
    logic               out_src_new_reg, out_dst_new_reg, out_done_reg;
    logic [ERR_W-1:0]   out_err_reg;
    logic [COUNT_W-1:0] out_total_reg;

    // memory ports
    logic               map_we, seen_we;
    logic [ID_W-1:0]    map_addr, seen_wdata, seen_rdata;
    logic [MAP_W-1:0]   map_wdata, map_rdata;
    logic [LABEL_W-1:0] seen_addr;

    // decision
    logic               src_v, dst_v, same, cap_err, ok;
    logic               src_new_c, dst_new_c;
    logic [COUNT_W-1:0] need;
    logic [LABEL_W-1:0] src_lab_c, dst_lab_c, nfl_lab, nfl_lab_plus;
    logic [ERR_W-1:0]   err_c;
    logic               range_err_c;

    fsnr_ram #(.WIDTH(MAP_W), .DEPTH(NODE_ID_SPACE)) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    fsnr_ram #(.WIDTH(ID_W), .DEPTH(MAX_BATCH_NODES)) u_seen_ram (
        .aclk  (aclk),
        .we    (seen_we),
        .addr  (seen_addr),
        .wdata (seen_wdata),
        .rdata (seen_rdata)
    );

    assign range_err_c = ({1'b0, s_source_node} >= node_count_limit) ||
                         ({1'b0, s_target_node} >= node_count_limit);

    // map entries arrive registered: source entry held, destination on rdata
    always_comb begin
        src_v        = src_ent_reg[MAP_W-1];
        same         = (src_reg == dst_reg);
        dst_v        = map_rdata[MAP_W-1];
        need         = {{(COUNT_W-1){1'b0}}, ~src_v} +
                       {{(COUNT_W-1){1'b0}}, ~same & ~dst_v};
        cap_err      = ({1'b0, nfl_reg} + {1'b0, need}) > CAPACITY;
        ok           = !range_err_reg && !cap_err;
        src_new_c    = ok && !src_v;
        dst_new_c    = ok && !same && !dst_v;
        nfl_lab      = nfl_reg[LABEL_W-1:0];
        nfl_lab_plus = nfl_lab + {{(LABEL_W-1){1'b0}}, ~src_v};
        src_lab_c    = '0;
        dst_lab_c    = '0;
        if (ok) begin
            src_lab_c = src_v ? src_ent_reg[LABEL_W-1:0] : nfl_lab;
            if (same) begin
                dst_lab_c = src_lab_c;
            end else begin
                dst_lab_c = dst_v ? map_rdata[LABEL_W-1:0] : nfl_lab_plus;
            end
        end
        if (range_err_reg) begin
            err_c = ERR_RANGE;
        end else if (cap_err) begin
            err_c = ERR_CAPACITY;
        end else begin
            err_c = ERR_NONE;
        end
    end

    always_comb begin
        map_we     = 1'b0;
        map_addr   = src_reg;
        map_wdata  = '0;
        seen_we    = 1'b0;
        seen_addr  = nfl_lab;
        seen_wdata = src_reg;
        case (cmd)
            CMD_CLEAR: begin
                map_we   = 1'b1;
                map_addr = clr_cnt_reg[ID_W-1:0];
            end
            CMD_ACCEPT: begin
                map_addr = s_source_node;
            end
            CMD_LOOK_DST: begin
                map_addr = dst_reg;
            end
            CMD_DECIDE: begin
                if (src_new_c) begin
                    map_we    = 1'b1;
                    map_addr  = src_reg;
                    map_wdata = {1'b1, nfl_lab};
                    seen_we   = 1'b1;
                end else if (dst_new_c) begin
                    map_we     = 1'b1;
                    map_addr   = dst_reg;
                    map_wdata  = {1'b1, nfl_lab};
                    seen_we    = 1'b1;
                    seen_wdata = dst_reg;
                end
            end
            CMD_WR_DST: begin
                map_we     = 1'b1;
                map_addr   = dst_reg;
                map_wdata  = {1'b1, nfl_lab};
                seen_we    = 1'b1;
                seen_wdata = dst_reg;
            end
            CMD_FLUSH: begin
                seen_addr = fcnt_reg[LABEL_W-1:0];
                map_we    = fpend_reg;
                map_addr  = seen_rdata;
            end
            default: begin
            end
        endcase
    end

    // control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nfl_reg     <= '0;
            fcnt_reg    <= '0;
            fpend_reg   <= 1'b0;
            clr_cnt_reg <= '0;
        end else begin
            case (cmd)
                CMD_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                CMD_ACCEPT: begin
                    fcnt_reg  <= '0;
                    fpend_reg <= 1'b0;
                end
                CMD_DECIDE: begin
                    if (src_new_c || dst_new_c) begin
                        nfl_reg <= nfl_reg + 1'b1;
                    end
                end
                CMD_WR_DST: begin
                    nfl_reg <= nfl_reg + 1'b1;
                end
                CMD_FLUSH: begin
                    fpend_reg <= (fcnt_reg != nfl_reg);
                    if (fcnt_reg != nfl_reg) begin
                        fcnt_reg <= fcnt_reg + 1'b1;
                    end else if (!fpend_reg) begin
                        nfl_reg <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_ACCEPT: begin
                src_reg       <= s_source_node;
                dst_reg       <= s_target_node;
                end_reg       <= s_batch_end;
                range_err_reg <= range_err_c;
            end
            CMD_LOOK_DST: begin
                src_ent_reg <= map_rdata;
            end
            CMD_DECIDE: begin
                src_lab_reg <= src_lab_c;
                dst_lab_reg <= dst_lab_c;
                src_new_reg <= src_new_c;
                dst_new_reg <= dst_new_c;
                err_reg     <= err_c;
            end
            CMD_FLUSH: begin
                if (fcnt_reg == nfl_reg && !fpend_reg) begin
                    total_reg <= nfl_reg;
                end
            end
            CMD_LOAD: begin
                out_src_lab_reg <= src_lab_reg;
                out_dst_lab_reg <= dst_lab_reg;
                out_src_new_reg <= src_new_reg;
                out_dst_new_reg <= dst_new_reg;
                out_err_reg     <= err_reg;
                out_total_reg   <= end_reg ? total_reg : '0;
                out_done_reg    <= end_reg;
            end
            default: begin
            end
        endcase
    end

    assign status.clr_done   = clr_cnt_reg[CLR_W-1];
    assign status.both_new   = src_new_c && dst_new_c;
    assign status.end_flag   = end_reg;
    assign status.flush_done = (fcnt_reg == nfl_reg) && !fpend_reg;

    assign m_source_label      = out_src_lab_reg;
    assign m_target_label      = out_dst_lab_reg;
    assign m_source_first_seen = out_src_new_reg;
    assign m_target_first_seen = out_dst_new_reg;
    assign m_error_code        = out_err_reg;
    assign m_batch_node_total  = out_total_reg;
    assign m_batch_done        = out_done_reg;

endmodule

// File: rtl/fsnr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnr_ctrl - sequencer of the relabeler
// Steps each beat through lookup, write, list flush and result hand-off.
// ----------------------------------------------------------------------------
module fsnr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  fsnr_pkg::status_t status,
    output fsnr_pkg::cmd_t    cmd
);
    import fsnr_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_WR_DST,
        ST_FLUSH,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = CMD_NONE;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_INIT_CLR: begin
                if (status.clr_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd = CMD_CLEAR;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_ACCEPT;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd        = CMD_LOOK_DST;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd = CMD_DECIDE;
                if (status.both_new) begin
                    state_next = ST_WR_DST;
                end else if (status.end_flag) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_WR_DST: begin
                cmd        = CMD_WR_DST;
                state_next = status.end_flag ? ST_FLUSH : ST_RESULT;
            end
            ST_FLUSH: begin
                cmd = CMD_FLUSH;
                if (status.flush_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd          = CMD_LOAD;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT_CLR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: rtl/first_seen_node_relabeler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_seen_node_relabeler - dense per-batch relabelling of graph node ids
// Gives each node of a batch of edges a label in order of first appearance.
// ----------------------------------------------------------------------------
//  port group | direction | beat contents
//  -----------+-----------+---------------------------------------------------
//  s_*        | in        | source_node, target_node, batch_end
//  m_*        | out       | both labels, first-seen flags, error, node total,
//             |           | batch_done
//  p*         | APB       | node_count_limit at byte address 0
//
//  Sequence: a beat passes through accept, source lookup, destination
//  lookup and decision, and result load, with a second write step when both
//  nodes are new, since the label map has a single port and takes one write
//  a cycle. A batch_end beat adds a walk over the batch's node list that
//  invalidates its map entries.
//  Reset: after aresetn the map is swept clear before the first beat is
//  taken; APB writes are taken throughout.
//  Stalls: the next beat is accepted while a result waits in the output
//  register; only the result load waits for m_ready.
// ----------------------------------------------------------------------------
module first_seen_node_relabeler (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fsnr_pkg::ID_W-1:0]    s_source_node,
    input  logic [fsnr_pkg::ID_W-1:0]    s_target_node,
    input  logic                         s_batch_end,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fsnr_pkg::LABEL_W-1:0] m_source_label,
    output logic [fsnr_pkg::LABEL_W-1:0] m_target_label,
    output logic                         m_source_first_seen,
    output logic                         m_target_first_seen,
    output logic [fsnr_pkg::ERR_W-1:0]   m_error_code,
    output logic [fsnr_pkg::COUNT_W-1:0] m_batch_node_total,
    output logic                         m_batch_done,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fsnr_pkg::PADDR_W-1:0] paddr,
    input  logic [fsnr_pkg::PDATA_W-1:0] pwdata,
    output logic [fsnr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import fsnr_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic               reg_hit;
    cmd_t               cmd;
    status_t            status;

    // single register; paddr[2] selects the word, low bits ignored
    assign reg_hit = (paddr[2] == REG_NODE_COUNT_LIMIT);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= NODE_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = reg_hit ? {{(PDATA_W-LIMIT_W){1'b0}}, limit_reg} : '0;

    fsnr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fsnr_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .node_count_limit    (limit_reg),
        .s_source_node       (s_source_node),
        .s_target_node       (s_target_node),
        .s_batch_end         (s_batch_end),
        .m_source_label      (m_source_label),
        .m_target_label      (m_target_label),
        .m_source_first_seen (m_source_first_seen),
        .m_target_first_seen (m_target_first_seen),
        .m_error_code        (m_error_code),
        .m_batch_node_total  (m_batch_node_total),
        .m_batch_done        (m_batch_done)
    );

endmodule

// File: rtl/fsnr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsnr_checker - port-level checks of the relabeler
// Watches the beat channels only; bound to the top level below.
// ----------------------------------------------------------------------------
module fsnr_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [fsnr_pkg::LABEL_W-1:0] m_source_label,
    input logic [fsnr_pkg::LABEL_W-1:0] m_target_label,
    input logic                         m_source_first_seen,
    input logic                         m_target_first_seen,
    input logic [fsnr_pkg::ERR_W-1:0]   m_error_code
);
    import fsnr_pkg::*;

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one beat in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_source_label) &&
                                   $stable(m_target_label) && $stable(m_error_code)))
        else $error("stalled result changed");

    // a rejected edge carries no labels
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code != ERR_NONE) |->
            (m_source_label == '0 && m_target_label == '0 &&
             !m_source_first_seen && !m_target_first_seen))
        else $error("rejected edge carries labels");

    // two new nodes take consecutive labels, source first
    a_new_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_source_first_seen && m_target_first_seen) |->
            (m_target_label == m_source_label + 1'b1))
        else $error("new labels not consecutive");

endmodule

bind first_seen_node_relabeler fsnr_checker u_fsnr_checker (.*);

// File: tb/first_seen_node_relabeler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_seen_node_relabeler_test - self-checking bench for the node relabeler
// Drives edge beats with random gaps and result stalls. A local relabelling
// model predicts every result beat, and each received beat is compared field
// by field. The node count limit is changed over APB only between phases,
// once the block is idle.
// ----------------------------------------------------------------------------
module first_seen_node_relabeler_test;
    import fsnr_pkg::*;

    // Cycles with no beat on either side before the run is abandoned. The
    // clearing sweep after reset alone covers all NODE_ID_SPACE map entries, and a
    // batch close walks up to MAX_BATCH_NODES list entries.
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 64;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [ID_W-1:0] source_node;
        logic [ID_W-1:0] target_node;
        logic            batch_end;
    } edge_beat_t;

    typedef struct packed {
        logic [LABEL_W-1:0] source_label;
        logic [LABEL_W-1:0] target_label;
        logic               source_first_seen;
        logic               target_first_seen;
        logic [ERR_W-1:0]   error_code;
        logic [COUNT_W-1:0] batch_node_total;
        logic               batch_done;
    } relabel_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [ID_W-1:0]     s_source_node = '0;
    logic [ID_W-1:0]     s_target_node = '0;
    logic                s_batch_end   = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [LABEL_W-1:0]  m_source_label;
    logic [LABEL_W-1:0]  m_target_label;
    logic                m_source_first_seen;
    logic                m_target_first_seen;
    logic [ERR_W-1:0]    m_error_code;
    logic [COUNT_W-1:0]  m_batch_node_total;
    logic                m_batch_done;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    first_seen_node_relabeler u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_source_node       (s_source_node),
        .s_target_node       (s_target_node),
        .s_batch_end         (s_batch_end),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_source_label      (m_source_label),
        .m_target_label      (m_target_label),
        .m_source_first_seen (m_source_first_seen),
        .m_target_first_seen (m_target_first_seen),
        .m_error_code        (m_error_code),
        .m_batch_node_total  (m_batch_node_total),
        .m_batch_done        (m_batch_done),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Relabelling model: own copy of the map, the node list and the limit
    // ------------------------------------------------------------------------
    logic [LABEL_W-1:0] node_label [NODE_ID_SPACE];
    bit                 node_known [NODE_ID_SPACE];
    logic [ID_W-1:0]    batch_nodes [MAX_BATCH_NODES];
    int unsigned        labels_used = 0;
    logic [LIMIT_W-1:0] id_limit    = NODE_LIMIT_RESET;

    edge_beat_t  pending_edges[$];
    relabel_t    expected_labels[$];
    int unsigned edges_queued   = 0;
    int unsigned edges_accepted = 0;
    int unsigned fault_count    = 0;
    bit          quiet          = 1'b0;   // no idling on either side
    int          src_idle       = 0;
    int          sink_stall     = 0;
    int          idle_cycles    = 0;
    edge_beat_t  held_beat;

    function automatic logic [LABEL_W-1:0] give_label(logic [ID_W-1:0] id);
        logic [LABEL_W-1:0] lab;
        lab = LABEL_W'(labels_used);
        node_label[id]         = lab;
        node_known[id]         = 1'b1;
        batch_nodes[lab]       = id;
        labels_used            = labels_used + 1;
        return lab;
    endfunction

    function automatic relabel_t relabel_edge(edge_beat_t b);
        relabel_t    r;
        int unsigned need;
        r = '0;
        if ({1'b0, b.source_node} >= id_limit || {1'b0, b.target_node} >= id_limit) begin
            r.error_code = ERR_RANGE;
        end else begin
            need = 0;
            if (!node_known[b.source_node])
                need++;
            if (b.target_node != b.source_node && !node_known[b.target_node])
                need++;
            if (labels_used + need > MAX_BATCH_NODES) begin
                r.error_code = ERR_CAPACITY;
            end else begin
                // source first, so a self-loop sees its own fresh label
                if (node_known[b.source_node]) begin
                    r.source_label = node_label[b.source_node];
                end else begin
                    r.source_label      = give_label(b.source_node);
                    r.source_first_seen = 1'b1;
                end
                if (node_known[b.target_node]) begin
                    r.target_label = node_label[b.target_node];
                end else begin
                    r.target_label      = give_label(b.target_node);
                    r.target_first_seen = 1'b1;
                end
            end
        end
        // batch closes even on a rejected beat
        if (b.batch_end) begin
            r.batch_node_total = COUNT_W'(labels_used);
            r.batch_done       = 1'b1;
            for (int i = 0; i < labels_used; i++)
                node_known[batch_nodes[i]] = 1'b0;
            labels_used = 0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Source driver: holds a beat until accepted, random idle bursts between
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_idle = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_labels.insert(expected_labels.size(), relabel_edge(held_beat));
                edges_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    src_idle = $urandom_range(1, 4) - 1;
                    s_valid <= 1'b0;
                end else if (pending_edges.size() > 0) begin
                    held_beat = pending_edges.pop_front();
                    s_valid       <= 1'b1;
                    s_source_node <= held_beat.source_node;
                    s_target_node <= held_beat.target_node;
                    s_batch_end   <= held_beat.batch_end;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: stalls in bursts, checks each beat against the oldest
    // prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        relabel_t got;
        relabel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_source_label, m_target_label, m_source_first_seen,
                        m_target_first_seen, m_error_code, m_batch_node_total,
                        m_batch_done};
                if (expected_labels.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t: result beat with nothing pending: lab %0d/%0d err %0d",
                                 $realtime, got.source_label, got.target_label,
                                 got.error_code);
                end else begin
                    want = expected_labels.pop_front();
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch  lab src/dst  new src/dst  err  total  done",
                                     $realtime);
                            $display("  expected  %4d/%4d      %0d/%0d       %0d  %4d   %0d",
                                     want.source_label, want.target_label,
                                     want.source_first_seen, want.target_first_seen,
                                     want.error_code, want.batch_node_total,
                                     want.batch_done);
                            $display("  actual    %4d/%4d      %0d/%0d       %0d  %4d   %0d",
                                     got.source_label, got.target_label,
                                     got.source_first_seen, got.target_first_seen,
                                     got.error_code, got.batch_node_total,
                                     got.batch_done);
                        end
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(1, 4) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any beat on either channel restarts the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_edge(input logic [ID_W-1:0] src, input logic [ID_W-1:0] dst,
                            input logic last);
        edge_beat_t b;
        b.source_node = src;
        b.target_node = dst;
        b.batch_end   = last;
        pending_edges.insert(pending_edges.size(), b);
        edges_queued++;
    endtask

    // Block idle: every queued beat taken, every result back, plus a margin
    task automatic settle();
        while (edges_accepted != edges_queued || expected_labels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // APB write of the limit register: setup cycle, then access cycle
    task automatic write_limit(input logic [PDATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NODE_COUNT_LIMIT, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        id_limit = value[LIMIT_W-1:0];
        @(negedge aclk);
    endtask

    // Mostly a small window of ids per batch so nodes repeat; some full-range
    // ids and some right around the limit
    function automatic logic [ID_W-1:0] pick_node(logic [ID_W-1:0] base);
        case ($urandom_range(0, 9))
            0, 1:    return ID_W'($urandom_range(0, 65535));
            2:       return ID_W'(id_limit + $urandom_range(0, 2) - 1);
            default: return base + ID_W'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic queue_random_batches(input int unsigned n_edges);
        int unsigned     made;
        int unsigned     len;
        int unsigned     top;
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] src;
        logic [ID_W-1:0] dst;
        made = 0;
        while (made < n_edges) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            top  = (id_limit > 16) ? id_limit - 16 : 0;
            base = ID_W'($urandom_range(0, (top > 65535) ? 65535 : top));
            for (int k = 0; k < len; k++) begin
                src = pick_node(base);
                dst = ($urandom_range(0, 7) == 0) ? src : pick_node(base);
                add_edge(src, dst, k == len - 1);
            end
            made += len;
        end
    endtask

    // k-th distinct id of a batch: odd stride keeps them all apart
    function automatic logic [ID_W-1:0] spread_id(int unsigned start, int unsigned stride,
                                                  int unsigned k);
        return ID_W'(start + k * stride);
    endfunction

    // One batch that fills the label space to the last label, probing the
    // capacity check with one label left and with none left
    task automatic queue_full_batch();
        int unsigned start;
        int unsigned stride;
        int unsigned fresh;
        logic [ID_W-1:0] old;
        start  = $urandom;
        stride = $urandom | 1;
        fresh  = 0;
        while (fresh < MAX_BATCH_NODES - 2) begin
            if (fresh > 0 && $urandom_range(0, 9) == 0) begin
                old = spread_id(start, stride, $urandom_range(0, fresh - 1));
                if ($urandom_range(0, 1))
                    add_edge(old, spread_id(start, stride, fresh), 1'b0);
                else
                    add_edge(spread_id(start, stride, fresh), old, 1'b0);
                fresh += 1;
            end else begin
                add_edge(spread_id(start, stride, fresh),
                         spread_id(start, stride, fresh + 1), 1'b0);
                fresh += 2;
            end
        end
        if (fresh == MAX_BATCH_NODES - 2) begin
            add_edge(spread_id(start, stride, 0), spread_id(start, stride, fresh), 1'b0);
            fresh += 1;
        end
        // one label left: two new nodes do not fit
        add_edge(spread_id(start, stride, fresh + 1), spread_id(start, stride, fresh + 2),
                 1'b0);
        // a new self-loop takes the last label
        add_edge(spread_id(start, stride, fresh), spread_id(start, stride, fresh), 1'b0);
        // full: any new node is refused, known ones still resolve
        add_edge(spread_id(start, stride, 3), spread_id(start, stride, fresh + 3), 1'b0);
        add_edge(spread_id(start, stride, fresh), spread_id(start, stride, 1), 1'b0);
        // closing beat itself refused, batch still reports 2048 nodes
        add_edge(spread_id(start, stride, fresh + 4), spread_id(start, stride, fresh + 5),
                 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset limit: new/known combinations, self-loop, extreme ids,
        // batches closed on their first beat
        add_edge(16'd0,     16'd0,     1'b0);
        add_edge(16'd0,     16'd65535, 1'b0);
        add_edge(16'd65535, 16'd0,     1'b0);
        add_edge(16'd65535, 16'd65535, 1'b0);
        add_edge(16'd5,     16'd7,     1'b0);
        add_edge(16'd7,     16'd5,     1'b1);
        add_edge(16'd100,   16'd200,   1'b1);
        add_edge(16'd300,   16'd300,   1'b1);
        settle();

        // range check on either side, and a batch closed on a refused beat
        write_limit(32'd1000);
        add_edge(16'd999,   16'd0,     1'b0);
        add_edge(16'd1000,  16'd3,     1'b0);
        add_edge(16'd3,     16'd1000,  1'b0);
        add_edge(16'd3,     16'd3,     1'b0);
        add_edge(16'd65535, 16'd65535, 1'b1);
        settle();

        // zero limit flags every id
        write_limit(32'd0);
        add_edge(16'd0, 16'd0, 1'b1);
        settle();

        write_limit(32'd1);
        add_edge(16'd0, 16'd0, 1'b0);
        add_edge(16'd0, 16'd1, 1'b1);
        settle();

        // random batches across a spread of limits; upper pwdata bits ignored
        write_limit(32'd65536);
        queue_random_batches(30);
        settle();
        write_limit(32'hFFFF_FFFF);
        queue_random_batches(30);
        settle();
        write_limit(32'd300);
        queue_random_batches(30);
        settle();
        write_limit(32'd2);
        queue_random_batches(30);
        settle();
        write_limit(32'($urandom_range(1, 65536)));
        queue_random_batches(30);
        settle();

        write_limit(32'd65536);
        queue_full_batch();
        settle();

        // closing stretch with both sides running flat out
        write_limit(32'($urandom_range(20000, 65536)));
        quiet = 1'b1;
        queue_random_batches(50);
        settle();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fault_count == 0 && expected_labels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fsnr_pkg.sv
rtl/fsnr_ram.sv
rtl/fsnr_datapath.sv
rtl/fsnr_ctrl.sv
rtl/first_seen_node_relabeler.sv
rtl/fsnr_checker.sv
tb/first_seen_node_relabeler_test.sv
